[rtl/cdp_pkg.sv]
// Shared types and constants for the complex dot product block.
// No dependencies; every other file imports this package.
`default_nettype none

package cdp_pkg;

   localparam int MAX_TAPS   = 1024;
   localparam int TAP_W      = $clog2(MAX_TAPS);
   localparam int COUNT_W    = 11;
   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int SUM_W      = 42;
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = RSP_PTR_W + 1;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef logic [TAP_W-1:0]           tap_type;
   typedef logic [COUNT_W-1:0]         count_type;
   typedef logic signed [SAMPLE_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   typedef struct packed {
      logic valid;
      logic last;
   } mac_ctrl_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } mac_status_type;

   typedef struct packed {
      sum_type sum_real;
      sum_type sum_imag;
   } result_type;

endpackage

`default_nettype wire

[rtl/cdp_if.sv]
// Valid/ready channel interfaces for the sample/load stream and the result stream.
// Depends on cdp_pkg for the payload types.
`default_nettype none

interface cdp_req_if;
   import cdp_pkg::*;

   logic     valid;
   logic     ready;
   logic     kind;
   tap_type  tap_index;
   word_type coef_real;
   word_type coef_imag;
   word_type sample_real;
   word_type sample_imag;

   modport source (
      output valid, kind, tap_index, coef_real, coef_imag, sample_real, sample_imag,
      input  ready
   );
   modport sink (
      input  valid, kind, tap_index, coef_real, coef_imag, sample_real, sample_imag,
      output ready
   );
endinterface

interface cdp_rsp_if;
   import cdp_pkg::*;

   logic    valid;
   logic    ready;
   sum_type sum_real;
   sum_type sum_imag;

   modport source (output valid, sum_real, sum_imag, input ready);
   modport sink   (input valid, sum_real, sum_imag, output ready);
endinterface

`default_nettype wire

[rtl/cdp_coef_mem.sv]
// Coefficient store: one synchronous RAM of MAX_TAPS complex words with a registered read.
// Depends on cdp_pkg.
`default_nettype none

module cdp_coef_mem
   import cdp_pkg::*;
(
   input  logic     clock,
   input  logic     wr_en,
   input  tap_type  wr_addr,
   input  word_type wr_real,
   input  word_type wr_imag,
   input  logic     rd_en,
   input  tap_type  rd_addr,
   output word_type rd_real,
   output word_type rd_imag
);

   logic [PROD_W-1:0] mem [MAX_TAPS];
   logic [PROD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_real, wr_imag};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_real = word_type'(rd_data_ff[PROD_W-1:SAMPLE_W]);
   assign rd_imag = word_type'(rd_data_ff[SAMPLE_W-1:0]);

endmodule

`default_nettype wire

[rtl/cdp_mac.sv]
// Complex multiply-accumulate pipeline: sample register, product register, accumulators.
// Depends on cdp_pkg; coefficients arrive from cdp_coef_mem in the cycle after issue.
`default_nettype none

module cdp_mac
   import cdp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  mac_ctrl_type   in_ctrl,
   input  word_type       in_sample_real,
   input  word_type       in_sample_imag,
   input  word_type       coef_real,
   input  word_type       coef_imag,
   output mac_status_type status,
   output logic           push,
   output result_type     push_data
);

   mac_ctrl_type s1_ctrl_ff, s2_ctrl_ff;
   word_type     a_ff, b_ff;
   prod_type     ac_ff, bd_ff, ad_ff, bc_ff;
   sum_type      acc_real_ff, acc_real_in;
   sum_type      acc_imag_ff, acc_imag_in;
   sum_type      sum_real, sum_imag;
   logic signed [PROD_W:0] term_real, term_imag;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= in_ctrl;
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   // Sample stage lines up with the coefficient read; product stage follows.
   always_ff @(posedge clock) begin
      if (in_ctrl.valid) begin
         a_ff <= in_sample_real;
         b_ff <= in_sample_imag;
      end
      if (s1_ctrl_ff.valid) begin
         ac_ff <= a_ff * coef_real;
         bd_ff <= b_ff * coef_imag;
         ad_ff <= a_ff * coef_imag;
         bc_ff <= b_ff * coef_real;
      end
   end

   always_comb begin
      term_real = (PROD_W+1)'(ac_ff) - (PROD_W+1)'(bd_ff);
      term_imag = (PROD_W+1)'(ad_ff) + (PROD_W+1)'(bc_ff);
      sum_real  = acc_real_ff + SUM_W'(term_real);
      sum_imag  = acc_imag_ff + SUM_W'(term_imag);
      acc_real_in = acc_real_ff;
      acc_imag_in = acc_imag_ff;
      if (s2_ctrl_ff.valid) begin
         acc_real_in = s2_ctrl_ff.last ? '0 : sum_real;
         acc_imag_in = s2_ctrl_ff.last ? '0 : sum_imag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_real_ff <= '0;
         acc_imag_ff <= '0;
      end else begin
         acc_real_ff <= acc_real_in;
         acc_imag_ff <= acc_imag_in;
      end
   end

   assign push               = s2_ctrl_ff.valid && s2_ctrl_ff.last;
   assign push_data.sum_real = sum_real;
   assign push_data.sum_imag = sum_imag;
   assign status.s1_valid    = s1_ctrl_ff.valid;
   assign status.s2_valid    = s2_ctrl_ff.valid;

endmodule

`default_nettype wire

[rtl/cdp_rsp_fifo.sv]
// Small result queue between the accumulator and the result channel.
// Depends on cdp_pkg and cdp_rsp_if.
`default_nettype none

module cdp_rsp_fifo
   import cdp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  result_type       push_data,
   output logic [RSP_CNT_W-1:0] count,
   cdp_rsp_if.source        rsp_ch
);

   result_type               entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0]     count_ff, count_in;
   logic                     pop;

   assign pop = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + RSP_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_ch.valid    = (count_ff != '0);
   assign rsp_ch.sum_real = entry_ff[rd_ptr_ff].sum_real;
   assign rsp_ch.sum_imag = entry_ff[rd_ptr_ff].sum_imag;
   assign count           = count_ff;

endmodule

`default_nettype wire

[rtl/complex_dot_product.sv]
// Top level of the complex dot product block: tap sequencing and flow control.
// Depends on cdp_pkg, cdp_if, cdp_coef_mem, cdp_mac and cdp_rsp_fifo.
//
// The block takes one beat per clock cycle while req_ch.ready is high, load or
// sample alike. A load writes one complex coefficient into a 1024-entry
// single-port-write RAM; a sample reads the coefficient at the running tap
// position, is multiplied in the next cycle and added into 42-bit accumulators
// in the one after. Results wait in a four-entry queue, and req_ch.ready falls
// only when that queue together with the samples still in the multiply pipeline
// could fill it, so a stalled consumer costs input rate only after several
// results are held back. A load followed at once by a sample at the same tap
// reads the new coefficient. The tap count register is written through csr_we
// and csr_wdata; the user must write it only while idle, which the block itself
// does not enforce. Zero acts as one and values above 1024 act as 1024.
`default_nettype none

module complex_dot_product
   import cdp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   cdp_req_if.sink   req_ch,
   cdp_rsp_if.source rsp_ch,
   input  logic      csr_we,
   input  count_type csr_wdata
);

   count_type            tap_count_ff;
   count_type            eff_count;
   tap_type              pos_ff;
   count_type            pos_next;
   logic                 accept, load_beat, sample_beat, last;
   mac_ctrl_type         issue;
   mac_status_type       mac_status;
   word_type             coef_real, coef_imag;
   logic                 push;
   result_type           push_data;
   logic [RSP_CNT_W-1:0] rsp_count;
   logic [RSP_CNT_W:0]   occupancy;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= count_type'(1);
      end else if (csr_we) begin
         tap_count_ff <= csr_wdata;
      end
   end

   always_comb begin
      eff_count = tap_count_ff;
      if (tap_count_ff == '0) begin
         eff_count = count_type'(1);
      end else if (tap_count_ff > count_type'(MAX_TAPS)) begin
         eff_count = count_type'(MAX_TAPS);
      end
   end

   // Every result still to come from the pipeline has a queue slot reserved.
   assign occupancy = (RSP_CNT_W+1)'(rsp_count)
                    + (RSP_CNT_W+1)'(mac_status.s1_valid)
                    + (RSP_CNT_W+1)'(mac_status.s2_valid);
   assign req_ch.ready = (occupancy < (RSP_CNT_W+1)'(RSP_DEPTH));

   assign accept      = req_ch.valid && req_ch.ready;
   assign load_beat   = accept && (req_ch.kind == KIND_LOAD);
   assign sample_beat = accept && (req_ch.kind == KIND_SAMPLE);
   assign pos_next    = count_type'(pos_ff) + count_type'(1);
   assign last        = (pos_next >= eff_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (sample_beat) begin
         pos_ff <= last ? '0 : pos_next[TAP_W-1:0];
      end
   end

   assign issue.valid = sample_beat;
   assign issue.last  = last;

   cdp_coef_mem u_coef_mem (
      .clock   (clock),
      .wr_en   (load_beat),
      .wr_addr (req_ch.tap_index),
      .wr_real (req_ch.coef_real),
      .wr_imag (req_ch.coef_imag),
      .rd_en   (sample_beat),
      .rd_addr (pos_ff),
      .rd_real (coef_real),
      .rd_imag (coef_imag)
   );

   cdp_mac u_mac (
      .clock          (clock),
      .reset          (reset),
      .in_ctrl        (issue),
      .in_sample_real (req_ch.sample_real),
      .in_sample_imag (req_ch.sample_imag),
      .coef_real      (coef_real),
      .coef_imag      (coef_imag),
      .status         (mac_status),
      .push           (push),
      .push_data      (push_data)
   );

   cdp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .count     (rsp_count),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire
